// File: rtl/core/lfr_pkg.sv
// Shared types and constants for the letter frequency ranker.
package lfr_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_WIDTH   = 16;
    localparam int BIN_W         = $clog2(ALPHABET_SIZE);
    localparam int NCAND_W       = $clog2(ALPHABET_SIZE + 1);
    localparam int LETTER_W      = 7;
    localparam int COUNT_OUT_W   = 16;
    localparam int CHAR_W        = 8;
    localparam int OUT_DATA_W    = 24;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(ALPHABET_SIZE - 1);

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    // Input kind codes carried on tuser.
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Command passed from the front end to the back end through the queue.
    typedef struct packed {
        logic             finish;
        logic [BIN_W-1:0] bin;
    } cmd_t;

endpackage

// File: rtl/core/lfr_front.sv
// Front end: accepts input transactions and turns letters and finishes into commands.
module lfr_front
(
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [lfr_pkg::CHAR_W-1:0]     s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    input  logic                           queue_full,
    output logic                           push,
    output lfr_pkg::cmd_t                  push_cmd
);

    logic                        is_lower;
    logic                        is_upper;
    logic [lfr_pkg::CHAR_W-1:0]  lower_off;
    logic [lfr_pkg::CHAR_W-1:0]  upper_off;
    logic                        is_finish;

    assign lower_off = s_axis_tdata - lfr_pkg::CHAR_LOWER_A;
    assign upper_off = s_axis_tdata - lfr_pkg::CHAR_UPPER_A;
    // The wrapped difference is below the alphabet size only for letters.
    assign is_lower  = lower_off < lfr_pkg::CHAR_W'(lfr_pkg::ALPHABET_SIZE);
    assign is_upper  = upper_off < lfr_pkg::CHAR_W'(lfr_pkg::ALPHABET_SIZE);
    assign is_finish = s_axis_tuser[0] == lfr_pkg::KIND_FINISH;

    assign s_axis_tready = !queue_full;

    always_comb
    begin
        push_cmd.finish = is_finish;
        push_cmd.bin    = is_lower ? lower_off[lfr_pkg::BIN_W-1:0]
                                   : upper_off[lfr_pkg::BIN_W-1:0];
        // Bytes that are not letters are dropped here.
        push = s_axis_tvalid && s_axis_tready && (is_finish || is_lower || is_upper);
    end

endmodule

// File: rtl/core/lfr_queue.sv
// Short command queue between the front end and the back end.
module lfr_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output lfr_pkg::cmd_t head_cmd
);

    lfr_pkg::cmd_t                 mem_reg [lfr_pkg::QUEUE_DEPTH];
    logic [lfr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lfr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lfr_pkg::QCNT_W-1:0]    fill_reg;
    logic [lfr_pkg::QCNT_W-1:0]    fill_next;
    logic                          do_pop;

    assign full      = fill_reg == lfr_pkg::QCNT_W'(lfr_pkg::QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head_cmd  = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/core/lfr_back.sv
// Back end: letter bins, ranking scan and the output register.
module lfr_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  lfr_pkg::cmd_t                      cmd,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lfr_pkg::LETTER_W-1:0]       out_letter,
    output logic [lfr_pkg::COUNT_OUT_W-1:0]    out_count,
    output logic                               out_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                              state_reg;
    logic [lfr_pkg::COUNT_WIDTH-1:0]     counts_reg [lfr_pkg::ALPHABET_SIZE];
    logic [lfr_pkg::ALPHABET_SIZE-1:0]   taken_reg;
    logic [lfr_pkg::BIN_W-1:0]           scan_idx_reg;
    logic [lfr_pkg::BIN_W-1:0]           best_idx_reg;
    logic [lfr_pkg::COUNT_WIDTH-1:0]     best_cnt_reg;
    logic                                found_reg;
    logic [lfr_pkg::NCAND_W-1:0]         ncand_reg;
    logic                                out_valid_reg;
    logic [lfr_pkg::LETTER_W-1:0]        out_letter_reg;
    logic [lfr_pkg::COUNT_OUT_W-1:0]     out_count_reg;
    logic                                out_last_reg;

    logic [lfr_pkg::COUNT_WIDTH-1:0]     cur_cnt;
    logic                                cand;
    logic                                better;
    logic                                out_free;
    logic                                final_pick;

    assign cur_cnt    = counts_reg[scan_idx_reg];
    assign cand       = !taken_reg[scan_idx_reg] && (cur_cnt != '0);
    // A strict compare keeps the lowest letter on equal counts.
    assign better     = cand && (!found_reg || (cur_cnt > best_cnt_reg));
    assign out_free   = !out_valid_reg || out_ready;
    assign final_pick = ncand_reg == lfr_pkg::NCAND_W'(1);
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;

    assign out_valid  = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
            begin
                counts_reg[i] <= '0;
            end
            taken_reg      <= '0;
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_cnt_reg   <= '0;
            found_reg      <= 1'b0;
            ncand_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_letter_reg <= '0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // In the emit state the load below handles the taken entry.
            if (out_valid_reg && out_ready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.finish)
                        begin
                            state_reg    <= ST_SCAN;
                            scan_idx_reg <= '0;
                            found_reg    <= 1'b0;
                            ncand_reg    <= '0;
                        end
                        else if (counts_reg[cmd.bin] != lfr_pkg::COUNT_MAX)
                        begin
                            counts_reg[cmd.bin] <= counts_reg[cmd.bin] + 1'b1;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (better)
                    begin
                        best_idx_reg <= scan_idx_reg;
                        best_cnt_reg <= cur_cnt;
                        found_reg    <= 1'b1;
                    end
                    if (cand)
                    begin
                        ncand_reg <= ncand_reg + 1'b1;
                    end
                    if (scan_idx_reg == lfr_pkg::LAST_BIN)
                    begin
                        if (found_reg || better)
                        begin
                            state_reg <= ST_EMIT;
                        end
                        else
                        begin
                            // Nothing counted: the bins are already zero.
                            taken_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_letter_reg <= lfr_pkg::LETTER_W'(lfr_pkg::CHAR_UPPER_A)
                                          + lfr_pkg::LETTER_W'(best_idx_reg);
                        out_count_reg  <= lfr_pkg::COUNT_OUT_W'(best_cnt_reg);
                        out_last_reg   <= final_pick;
                        if (final_pick)
                        begin
                            for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
                            begin
                                counts_reg[i] <= '0;
                            end
                            taken_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            taken_reg[best_idx_reg] <= 1'b1;
                            scan_idx_reg            <= '0;
                            found_reg               <= 1'b0;
                            ncand_reg               <= '0;
                            state_reg               <= ST_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/letter_frequency_ranker_top.sv
// Top level of the letter frequency ranker.
//
// Input channel s_axis: tuser[0] is the kind (0 = character byte, 1 = finish),
// tdata[7:0] is the byte. Letters are counted without regard to case in 26
// bins of 16 bits that saturate; other bytes are dropped at the front end.
// Output channel m_axis: tdata[6:0] is the uppercase letter, tdata[22:7] its
// count, tlast marks the final entry of a ranking. Entries come out by count
// descending, equal counts by letter ascending; a finish with no letters
// counted gives no output. The bins are cleared after each finish.
// Character bytes are taken one per cycle while the queue has room; a
// four-entry command queue lets input continue while a ranking is being
// produced. Each ranking entry takes one scan over the bins followed by a
// load of the output register; a finish with no letter counted takes a
// single scan over the bins and gives no output.
// Reset clears the bins, the queue and the output register. When the
// receiver stalls, the entry waits in the output register and the next entry
// is held in the back end until it is taken; once the queue fills, tready drops.
module letter_frequency_ranker_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lfr_pkg::CHAR_W-1:0]         s_axis_tdata,  // [7:0] char_code
    input  logic [0:0]                         s_axis_tuser,  // [0] kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lfr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [6:0] letter, [22:7] count
    output logic                               m_axis_tlast
);

    logic                                push;
    lfr_pkg::cmd_t                       push_cmd;
    logic                                pop;
    logic                                queue_full;
    logic                                queue_not_empty;
    lfr_pkg::cmd_t                       head_cmd;
    logic [lfr_pkg::LETTER_W-1:0]        out_letter;
    logic [lfr_pkg::COUNT_OUT_W-1:0]     out_count;

    lfr_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    lfr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    lfr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_not_empty),
        .cmd        (head_cmd),
        .cmd_pop    (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_letter (out_letter),
        .out_count  (out_count),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_count, out_letter};

endmodule

// File: rtl/core/lfr_checker.sv
// Port-level checks for the letter frequency ranker, bound to the top level.
module lfr_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [lfr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tlast
);

    // Every ranked entry names an uppercase letter.
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] >= 7'h41) && (m_axis_tdata[6:0] <= 7'h5A))
        else $error("ranked letter outside A to Z");

    // Letters with a zero count are never reported, and the pad bit stays clear.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:7] != '0) && !m_axis_tdata[23])
        else $error("ranked entry with zero count or pad bit set");

    // Within one ranking the counts never increase.
    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tdata[22:7] <= $past(m_axis_tdata[22:7]))))
        else $error("ranking counts out of order");

    // A stalled entry holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind letter_frequency_ranker_top lfr_checker u_lfr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: test/testbench.sv
// Testbench for the letter frequency ranker: directed and random text against a predictor.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [lfr_pkg::LETTER_W-1:0]    letter;
        logic [lfr_pkg::COUNT_OUT_W-1:0] count;
        logic                            last;
    } rank_entry_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [lfr_pkg::CHAR_W-1:0]     s_axis_tdata;
    logic [0:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [lfr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    logic [lfr_pkg::COUNT_WIDTH-1:0] letter_tally [lfr_pkg::ALPHABET_SIZE];
    rank_entry_t                     expected_ranking [$];
    int                              mismatch_count;
    int                              burst_left;
    logic [15:0]                     ready_pattern;
    logic [3:0]                      pattern_pos;

    letter_frequency_ranker_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bumps the bin of a letter byte, saturating; other bytes leave the bins alone.
    function automatic void tally_byte(input logic [lfr_pkg::CHAR_W-1:0] code);
        int idx;
        idx = -1;
        if (code >= lfr_pkg::CHAR_LOWER_A
            && code < lfr_pkg::CHAR_LOWER_A + lfr_pkg::ALPHABET_SIZE)
            idx = code - lfr_pkg::CHAR_LOWER_A;
        else if (code >= lfr_pkg::CHAR_UPPER_A
                 && code < lfr_pkg::CHAR_UPPER_A + lfr_pkg::ALPHABET_SIZE)
            idx = code - lfr_pkg::CHAR_UPPER_A;
        if (idx >= 0 && letter_tally[idx] != lfr_pkg::COUNT_MAX)
            letter_tally[idx] = letter_tally[idx] + 1'b1;
    endfunction

    // Selection sort over the bins: highest count first, lowest letter wins a tie.
    function automatic void rank_and_clear();
        bit          picked [lfr_pkg::ALPHABET_SIZE];
        int          best;
        int          first_entry;
        rank_entry_t entry;
        first_entry = expected_ranking.size();
        for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
            picked[i] = 1'b0;
        for (int n = 0; n < lfr_pkg::ALPHABET_SIZE; n++)
        begin
            best = -1;
            for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
            begin
                if (!picked[i] && letter_tally[i] != '0)
                begin
                    if (best < 0)
                        best = i;
                    else if (letter_tally[i] > letter_tally[best])
                        best = i;
                end
            end
            if (best < 0)
                break;
            picked[best] = 1'b1;
            entry.letter = lfr_pkg::LETTER_W'(lfr_pkg::CHAR_UPPER_A + best);
            entry.count  = lfr_pkg::COUNT_OUT_W'(letter_tally[best]);
            entry.last   = 1'b0;
            expected_ranking.push_back(entry);
        end
        if (expected_ranking.size() > first_entry)
            expected_ranking[expected_ranking.size() - 1].last = 1'b1;
        for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
            letter_tally[i] = '0;
    endfunction

    // Sends one transaction; the sender runs in bursts separated by random gaps.
    task automatic send_item(input logic kind, input logic [lfr_pkg::CHAR_W-1:0] code);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (kind == lfr_pkg::KIND_FINISH)
            rank_and_clear();
        else
            tally_byte(code);
        burst_left--;
    endtask

    // Holds the sender off until every predicted ranking entry has come out.
    task automatic wait_for_rankings();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_ranking.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_finish();
        send_item(lfr_pkg::KIND_FINISH, 8'hFF);
        send_item(lfr_pkg::KIND_CHAR, 8'h40);
        send_item(lfr_pkg::KIND_CHAR, 8'h5B);
        send_item(lfr_pkg::KIND_FINISH, 8'h00);
    endtask

    // Both cases fold into one bin; bytes next to the letter ranges and
    // high-bit lookalikes are dropped. A and Z tie and must come out in order.
    task automatic test_case_folding();
        send_item(lfr_pkg::KIND_CHAR, 8'h7A);
        send_item(lfr_pkg::KIND_CHAR, 8'h60);
        send_item(lfr_pkg::KIND_CHAR, 8'h61);
        send_item(lfr_pkg::KIND_CHAR, 8'h7B);
        send_item(lfr_pkg::KIND_CHAR, 8'h4D);
        send_item(lfr_pkg::KIND_CHAR, 8'h41);
        send_item(lfr_pkg::KIND_CHAR, 8'h00);
        send_item(lfr_pkg::KIND_CHAR, 8'hC1);
        send_item(lfr_pkg::KIND_CHAR, 8'hE1);
        send_item(lfr_pkg::KIND_CHAR, 8'h5A);
        send_item(lfr_pkg::KIND_FINISH, lfr_pkg::CHAR_LOWER_A);
        send_item(lfr_pkg::KIND_FINISH, 8'h5A);
    endtask

    task automatic test_full_alphabet();
        for (int i = lfr_pkg::ALPHABET_SIZE - 1; i >= 0; i--)
            send_item(lfr_pkg::KIND_CHAR,
                      ((i % 2) != 0) ? lfr_pkg::CHAR_W'(lfr_pkg::CHAR_UPPER_A + i)
                                     : lfr_pkg::CHAR_W'(lfr_pkg::CHAR_LOWER_A + i));
        send_item(lfr_pkg::KIND_FINISH, 8'h80);
    endtask

    task automatic test_random_text();
        int                         sent;
        int                         span;
        int                         base;
        bit                         paused;
        logic [lfr_pkg::CHAR_W-1:0] code;
        sent   = 0;
        paused = 1'b0;
        while (sent < 220)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                span = $urandom_range(1, lfr_pkg::ALPHABET_SIZE);
                base = $urandom_range(0, lfr_pkg::ALPHABET_SIZE - span);
                repeat ($urandom_range(0, 30))
                begin
                    if ($urandom_range(0, 9) == 0)
                        code = lfr_pkg::CHAR_W'($urandom);
                    else
                    begin
                        code = ($urandom_range(0, 1) != 0) ? lfr_pkg::CHAR_UPPER_A
                                                           : lfr_pkg::CHAR_LOWER_A;
                        code = code + lfr_pkg::CHAR_W'(base + $urandom_range(0, span - 1));
                        sent++;
                    end
                    send_item(lfr_pkg::KIND_CHAR, code);
                end
                send_item(lfr_pkg::KIND_FINISH, lfr_pkg::CHAR_W'($urandom));
                sent++;
            end
            else
            begin
                // Noise: any byte, with finishes mixed in at random.
                repeat ($urandom_range(1, 6))
                begin
                    send_item(1'($urandom), lfr_pkg::CHAR_W'($urandom));
                    sent++;
                end
            end
            if (!paused && sent >= 110)
            begin
                wait_for_rankings();
                paused = 1'b1;
            end
        end
        send_item(lfr_pkg::KIND_FINISH, 8'h00);
    endtask

    // The receiver follows a 16-bit ready pattern that is redrawn each time it wraps.
    initial
    begin
        m_axis_tready <= 1'b0;
        ready_pattern = 16'hFFFF;
        pattern_pos   = '0;
        forever
        begin
            @(posedge clk);
            if (pattern_pos == '0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'h8421;
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
                ready_pattern[0] = 1'b1;
            end
            m_axis_tready <= ready_pattern[pattern_pos];
            pattern_pos = pattern_pos + 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rank_entry_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_ranking.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected ranking entry letter %0d count %0d last %0d",
                         $time, m_axis_tdata[6:0], m_axis_tdata[22:7], m_axis_tlast);
            end
            else
            begin
                want = expected_ranking.pop_front();
                if (m_axis_tdata[6:0] !== want.letter)
                begin
                    mismatch_count++;
                    $display("%0t: letter mismatch: expected %0d actual %0d",
                             $time, want.letter, m_axis_tdata[6:0]);
                end
                if (m_axis_tdata[22:7] !== want.count)
                begin
                    mismatch_count++;
                    $display("%0t: count mismatch for letter %0d: expected %0d actual %0d",
                             $time, want.letter, want.count, m_axis_tdata[22:7]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last mismatch for letter %0d: expected %0d actual %0d",
                             $time, want.letter, want.last, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= lfr_pkg::KIND_CHAR;
        mismatch_count = 0;
        burst_left     = 0;
        for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++)
            letter_tally[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_finish();
        test_case_folding();
        test_full_alphabet();
        test_random_text();

        wait_for_rankings();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
